// File: hw/rtl/ibo_pkg.sv
`timescale 1ns / 1ps

package ibo_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int ERR_W     = 17;
  localparam int ABS_W     = 16;
  localparam int ESUM_W    = 17;
  localparam int GAIN_W    = 24;
  localparam int PASS_W    = 8;
  localparam int ACC_W     = 48;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;

  // Gravity on accel Z and the quiet threshold on the summed error
  localparam logic signed [ERR_W-1:0] GRAVITY_LSB = 17'sd16384;
  localparam logic [ESUM_W-1:0]       QUIET_SUM   = 17'd100;

  // Register reset values and the pass counter ceiling
  localparam logic [GAIN_W-1:0] KP_START_RST   = 24'd314573;
  localparam logic [GAIN_W-1:0] KI_START_RST   = 24'd94372;
  localparam logic [PASS_W-1:0] PASS_LIMIT_RST = 8'd1;
  localparam logic [PASS_W-1:0] PASS_MAX       = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_MODE = 4'd0,
    REG_KP_START   = 4'd1,
    REG_KI_START   = 4'd2,
    REG_PASS_LIMIT = 4'd3
  } ibo_reg_t;

  // Per-item controls sent to each axis datapath
  typedef struct packed {
    logic load;   // seed integral from the offset word
    logic run;    // PI update on a sample
    logic accel;  // accel mode (scale 8, LSB kept)
  } ibo_axis_ctl_t;

  // Status from the pass controller
  typedef struct packed {
    logic done;      // registered finished flag
    logic pass_end;  // this sample closed a pass
    logic finished;  // finished flag after this item
  } ibo_stat_t;

endpackage

// File: hw/rtl/ibo_axis.sv
`timescale 1ns / 1ps

module ibo_axis import ibo_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ibo_axis_ctl_t               ctl,
  input  logic                        grav_sub,
  input  logic signed [SAMPLE_W-1:0]  word,
  input  logic        [GAIN_W-1:0]    kp,
  input  logic        [GAIN_W-1:0]    ki,
  output logic signed [SAMPLE_W-1:0]  offset_nxt,
  output logic        [ABS_W-1:0]     abs_err
);

  localparam int SH_ACC = GAIN_FRAC_BITS + 3;
  localparam int SH_GYR = GAIN_FRAC_BITS + 2;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RND_W  = ACC_W + 2;
  localparam int PRD_W  = GAIN_W + ERR_W + 1;
  localparam logic [RND_W-1:0] HALF_ACC = RND_W'(1) << (SH_ACC - 1);
  localparam logic [RND_W-1:0] HALF_GYR = RND_W'(1) << (SH_GYR - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0]    integral_r, integral_nxt;
  logic                       kept_lsb_r, kept_lsb_nxt;
  logic signed [SAMPLE_W-1:0] last_offset_r;

  logic signed [ERR_W-1:0]    rd, err;
  logic signed [PRD_W-1:0]    ki_prod, kp_prod;
  logic signed [SUM_W-1:0]    int_sum, pi_sum;
  logic signed [ACC_W-1:0]    int_sat, ld_ext;
  logic        [SUM_W-1:0]    mag;
  logic        [RND_W-1:0]    rnd, q;
  logic signed [SAMPLE_W-1:0] q_sat, q_out;

  // Reading relative to gravity, error and its magnitude
  always_comb begin
    rd      = {word[SAMPLE_W-1], word} - (grav_sub ? GRAVITY_LSB : '0);
    err     = -rd;
    abs_err = rd[ERR_W-1] ? ABS_W'(err) : ABS_W'(rd);
  end

  // PI products, saturated integral and rounded offset
  always_comb begin
    ki_prod = $signed({1'b0, ki}) * err;
    kp_prod = $signed({1'b0, kp}) * err;
    int_sum = {integral_r[ACC_W-1], integral_r} + SUM_W'(ki_prod);
    if (int_sum[SUM_W-1] != int_sum[ACC_W-1]) begin
      int_sat = int_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      int_sat = int_sum[ACC_W-1:0];
    end
    pi_sum = {int_sat[ACC_W-1], int_sat} + SUM_W'(kp_prod);
    mag    = pi_sum[SUM_W-1] ? SUM_W'(-pi_sum) : SUM_W'(pi_sum);
    rnd    = {1'b0, mag} + (ctl.accel ? HALF_ACC : HALF_GYR);
    q      = ctl.accel ? (rnd >> SH_ACC) : (rnd >> SH_GYR);
    // Saturate to the 16-bit offset word
    if (pi_sum[SUM_W-1]) begin
      q_sat = (q > RND_W'(32768)) ? 16'sh8000 : SAMPLE_W'(-q);
    end else begin
      q_sat = (q > RND_W'(32767)) ? 16'sh7fff : SAMPLE_W'(q);
    end
    q_out = ctl.accel ? {q_sat[SAMPLE_W-1:1], kept_lsb_r} : q_sat;
  end

  // Next state and the offset this item reports
  always_comb begin
    ld_ext       = {{(ACC_W-SAMPLE_W){word[SAMPLE_W-1]}}, word};
    integral_nxt = integral_r;
    kept_lsb_nxt = kept_lsb_r;
    offset_nxt   = last_offset_r;
    if (ctl.load) begin
      integral_nxt = ctl.accel ? (ld_ext << SH_ACC) : (ld_ext << SH_GYR);
      kept_lsb_nxt = ctl.accel & word[0];
      offset_nxt   = word;
    end else if (ctl.run) begin
      integral_nxt = int_sat;
      offset_nxt   = q_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r    <= '0;
      kept_lsb_r    <= 1'b0;
      last_offset_r <= '0;
    end else if (ctl.load || ctl.run) begin
      integral_r    <= integral_nxt;
      kept_lsb_r    <= kept_lsb_nxt;
      last_offset_r <= offset_nxt;
    end
  end

endmodule

// File: hw/rtl/ibo_ctrl.sv
`timescale 1ns / 1ps

module ibo_ctrl import ibo_pkg::*; #(
  parameter int SAMPLES_PER_PASS = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                sample,
  input  logic [ESUM_W-1:0]   esum,
  input  logic [GAIN_W-1:0]   kp_start,
  input  logic [GAIN_W-1:0]   ki_start,
  input  logic [PASS_W-1:0]   pass_limit,
  output logic [GAIN_W-1:0]   kp_now,
  output logic [GAIN_W-1:0]   ki_now,
  output ibo_stat_t           stat
);

  localparam int CNT_W = $clog2(SAMPLES_PER_PASS + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [PASS_W-1:0] pass_r, pass_nxt, pass_inc;
  logic [GAIN_W-1:0] kp_r, kp_nxt, ki_r, ki_nxt;
  logic              done_r, done_nxt;
  logic              run, close;
  logic [GAIN_W+1:0] kp3, ki3;

  assign run      = sample && !done_r;
  assign cnt_inc  = cnt_r + 1'b1;
  assign close    = run && ((esum < QUIET_SUM) || (cnt_inc >= CNT_W'(SAMPLES_PER_PASS)));
  assign pass_inc = (pass_r < PASS_MAX) ? pass_r + 1'b1 : pass_r;
  // Gain decay by 3/4, truncating
  assign kp3      = {2'b00, kp_r} + {1'b0, kp_r, 1'b0};
  assign ki3      = {2'b00, ki_r} + {1'b0, ki_r, 1'b0};

  always_comb begin
    cnt_nxt  = cnt_r;
    pass_nxt = pass_r;
    kp_nxt   = kp_r;
    ki_nxt   = ki_r;
    done_nxt = done_r;
    if (load) begin
      cnt_nxt  = '0;
      pass_nxt = '0;
      kp_nxt   = kp_start;
      ki_nxt   = ki_start;
      done_nxt = 1'b0;
    end else if (close) begin
      cnt_nxt  = '0;
      pass_nxt = pass_inc;
      kp_nxt   = kp3[GAIN_W+1:2];
      ki_nxt   = ki3[GAIN_W+1:2];
      done_nxt = (pass_inc >= pass_limit);
    end else if (run) begin
      cnt_nxt  = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pass_r <= '0;
      kp_r   <= '0;
      ki_r   <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pass_r <= pass_nxt;
      kp_r   <= kp_nxt;
      ki_r   <= ki_nxt;
      done_r <= done_nxt;
    end
  end

  assign kp_now        = kp_r;
  assign ki_now        = ki_r;
  assign stat.done     = done_r;
  assign stat.pass_end = close;
  assign stat.finished = done_nxt;

endmodule

// File: hw/rtl/imu_bias_offset_calibrator_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                 Contents
// in_      in   in_tvalid / in_tready     offset words or raw sample, kind in tuser
// out_     out  out_tvalid / out_tready   new offsets, error sum, pass end, finished
// cfg_     in   cfg_valid / cfg_ready     register index and write data
//
// One request is taken per cycle unless a stalled result fills both stages; each
// result passes the input register, then the PI datapath into the result register.
// The per-item path is one 25x17 multiply per gain and axis plus the 48-bit
// integral add, saturate and round, all in the cycle before the result register.
// rst_n is synchronous: integrals, counters, gains and flags clear, registers
// take their reset values. A stalled result holds the pipeline and in_tready
// drops only when both stages are full. cfg_ready is always high.

module imu_bias_offset_calibrator_core import ibo_pkg::*; #(
  parameter int SAMPLES_PER_PASS = 100,
  parameter int GAIN_FRAC_BITS   = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,   // axis_x[15:0], axis_y[31:16], axis_z[47:32]
  input  logic                 in_tuser,   // kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // offset_x, offset_y, offset_z, error_sum[64:48], zero pad
  output logic                 out_tlast,  // pass_end
  output logic                 out_tuser,  // finished
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic              accel_mode_r;
  logic [GAIN_W-1:0] kp_start_r, ki_start_r;
  logic [PASS_W-1:0] pass_limit_r;

  logic                       in_vld_r, kind_r;
  logic signed [SAMPLE_W-1:0] x_r, y_r, z_r;
  logic                       out_vld_r, pass_end_r, finished_r;
  logic signed [SAMPLE_W-1:0] ox_r, oy_r, oz_r;
  logic [ESUM_W-1:0]          esum_r;

  logic                       adv, step, load, sample;
  ibo_axis_ctl_t              actl;
  ibo_stat_t                  stat;
  logic [GAIN_W-1:0]          kp_now, ki_now;
  logic signed [SAMPLE_W-1:0] ox_nxt, oy_nxt, oz_nxt;
  logic [ABS_W-1:0]           ax, ay, az;
  logic [ESUM_W-1:0]          esum;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_mode_r <= 1'b0;
      kp_start_r   <= KP_START_RST;
      ki_start_r   <= KI_START_RST;
      pass_limit_r <= PASS_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACCEL_MODE: accel_mode_r <= cfg_data[0];
        REG_KP_START:   kp_start_r   <= cfg_data[GAIN_W-1:0];
        REG_KI_START:   ki_start_r   <= cfg_data[GAIN_W-1:0];
        REG_PASS_LIMIT: pass_limit_r <= cfg_data[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign step      = in_vld_r && adv;
  assign load      = step && !kind_r;
  assign sample    = step && kind_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      x_r    <= in_tdata[15:0];
      y_r    <= in_tdata[31:16];
      z_r    <= in_tdata[47:32];
    end
  end

  // Axis datapaths and pass controller
  assign actl.load  = load;
  assign actl.run   = sample && !stat.done;
  assign actl.accel = accel_mode_r;

  ibo_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .grav_sub(1'b0), .word(x_r),
    .kp(kp_now), .ki(ki_now), .offset_nxt(ox_nxt), .abs_err(ax)
  );

  ibo_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .grav_sub(1'b0), .word(y_r),
    .kp(kp_now), .ki(ki_now), .offset_nxt(oy_nxt), .abs_err(ay)
  );

  ibo_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_z (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .grav_sub(accel_mode_r), .word(z_r),
    .kp(kp_now), .ki(ki_now), .offset_nxt(oz_nxt), .abs_err(az)
  );

  assign esum = ESUM_W'(ax) + ESUM_W'(ay) + ESUM_W'(az);

  ibo_ctrl #(.SAMPLES_PER_PASS(SAMPLES_PER_PASS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .load(load), .sample(sample), .esum(esum),
    .kp_start(kp_start_r), .ki_start(ki_start_r), .pass_limit(pass_limit_r),
    .kp_now(kp_now), .ki_now(ki_now), .stat(stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ox_r       <= ox_nxt;
      oy_r       <= oy_nxt;
      oz_r       <= oz_nxt;
      esum_r     <= kind_r ? esum : '0;
      pass_end_r <= stat.pass_end;
      finished_r <= stat.finished;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, esum_r, oz_r, oy_r, ox_r};
  assign out_tlast  = pass_end_r;
  assign out_tuser  = finished_r;

endmodule
